// ===== hdl/spicmdrd_pkg.sv =====
// Package for the SPI command-then-read master.
// Holds the sequencer phase type and the per-tick result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spicmdrd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DESEL   = 3'd1,
    PH_SEL     = 3'd2,
    PH_SEND    = 3'd3,
    PH_GAP     = 3'd4,
    PH_RESEL   = 3'd5,
    PH_READ    = 3'd6,
    PH_RELEASE = 3'd7
  } phase_e;

  localparam int unsigned CfgWidth      = 6;
  localparam logic [5:0]  CmdBitsReset  = 6'd26;
  localparam logic [5:0]  BitsPerByte   = 6'd8;
  localparam int unsigned ResDataWidth  = 16;

  // Result of one tick.
  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic       byte_valid;
    logic [7:0] rd_byte;
    logic       last_byte;
    logic       busy;
  } tick_res_t;

endpackage

`default_nettype wire

// ===== hdl/spicmdrd_core.sv =====
// Sequencer of the SPI command-then-read master: state registers and tick logic.
// Advances one half-bit tick per step request. Depends on spicmdrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spicmdrd_core #(
  parameter int unsigned COMMAND_WIDTH = 32
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_we_i,
  input  wire [spicmdrd_pkg::CfgWidth-1:0]        cfg_data_i,
  input  wire                                     step_i,
  input  wire                                     start_req_i,
  input  wire [COMMAND_WIDTH-1:0]                 command_word_i,
  input  wire [7:0]                               read_count_i,
  input  wire                                     miso_level_i,
  output spicmdrd_pkg::tick_res_t                 res_o
);

  spicmdrd_pkg::phase_e phase_q, phase_d;
  logic [COMMAND_WIDTH-1:0] send_shift_q, send_shift_d;
  logic [5:0] bit_index_q, bit_index_d;
  logic [5:0] bit_index_inc;
  logic       second_half_q, second_half_d;
  logic [7:0] receive_shift_q, receive_shift_d;
  logic [7:0] rx_next;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] bytes_dec;
  logic       cs_q, cs_d, clk_q, clk_d, mosi_q, mosi_d;
  logic [5:0] command_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_bits_q <= spicmdrd_pkg::CmdBitsReset;
    end else if (cfg_we_i) begin
      command_bits_q <= cfg_data_i;
    end
  end

  assign bit_index_inc = bit_index_q + 6'd1;
  assign rx_next       = {receive_shift_q[6:0], miso_level_i};
  assign bytes_dec     = bytes_left_q - 8'd1;

  always_comb begin
    phase_d         = phase_q;
    send_shift_d    = send_shift_q;
    bit_index_d     = bit_index_q;
    second_half_d   = second_half_q;
    receive_shift_d = receive_shift_q;
    bytes_left_d    = bytes_left_q;
    cs_d            = cs_q;
    clk_d           = clk_q;
    mosi_d          = mosi_q;
    res_o           = '0;
    res_o.busy      = 1'b1;

    unique case (phase_q)
      spicmdrd_pkg::PH_IDLE: begin
        if (start_req_i) begin
          send_shift_d    = command_word_i;
          bytes_left_d    = read_count_i;
          bit_index_d     = '0;
          second_half_d   = 1'b0;
          receive_shift_d = '0;
          cs_d            = 1'b1;
          phase_d         = spicmdrd_pkg::PH_DESEL;
        end else begin
          res_o.busy = 1'b0;
        end
      end
      spicmdrd_pkg::PH_DESEL, spicmdrd_pkg::PH_SEL: begin
        cs_d          = 1'b0;
        bit_index_d   = '0;
        second_half_d = 1'b0;
        phase_d       = (command_bits_q == '0) ? spicmdrd_pkg::PH_GAP
                                               : spicmdrd_pkg::PH_SEND;
      end
      spicmdrd_pkg::PH_SEND: begin
        if (!second_half_q) begin
          clk_d         = 1'b1;
          mosi_d        = send_shift_q[0];
          send_shift_d  = send_shift_q >> 1;
          second_half_d = 1'b1;
        end else begin
          clk_d         = 1'b0;
          second_half_d = 1'b0;
          bit_index_d   = bit_index_inc;
          if (bit_index_inc >= command_bits_q) begin
            phase_d = spicmdrd_pkg::PH_GAP;
          end
        end
      end
      spicmdrd_pkg::PH_GAP: begin
        cs_d    = 1'b1;
        phase_d = spicmdrd_pkg::PH_RESEL;
      end
      spicmdrd_pkg::PH_RESEL: begin
        cs_d            = 1'b0;
        bit_index_d     = '0;
        second_half_d   = 1'b0;
        receive_shift_d = '0;
        phase_d         = (bytes_left_q == '0) ? spicmdrd_pkg::PH_RELEASE
                                               : spicmdrd_pkg::PH_READ;
      end
      spicmdrd_pkg::PH_READ: begin
        if (!second_half_q) begin
          clk_d         = 1'b1;
          second_half_d = 1'b1;
        end else begin
          clk_d           = 1'b0;
          second_half_d   = 1'b0;
          receive_shift_d = rx_next;
          bit_index_d     = bit_index_inc;
          if (bit_index_inc >= spicmdrd_pkg::BitsPerByte) begin
            res_o.byte_valid = 1'b1;
            res_o.rd_byte    = rx_next;
            res_o.last_byte  = (bytes_dec == '0);
            bytes_left_d     = bytes_dec;
            bit_index_d      = '0;
            receive_shift_d  = '0;
            if (bytes_dec == '0) begin
              phase_d = spicmdrd_pkg::PH_RELEASE;
            end
          end
        end
      end
      spicmdrd_pkg::PH_RELEASE: begin
        cs_d    = 1'b1;
        phase_d = spicmdrd_pkg::PH_IDLE;
      end
      default: begin
        phase_d = spicmdrd_pkg::PH_IDLE;
      end
    endcase

    res_o.cs_n = cs_d;
    res_o.sclk = clk_d;
    res_o.mosi = mosi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= spicmdrd_pkg::PH_IDLE;
      send_shift_q    <= '0;
      bit_index_q     <= '0;
      second_half_q   <= 1'b0;
      receive_shift_q <= '0;
      bytes_left_q    <= '0;
      cs_q            <= 1'b1;
      clk_q           <= 1'b1;
      mosi_q          <= 1'b1;
    end else if (step_i) begin
      phase_q         <= phase_d;
      send_shift_q    <= send_shift_d;
      bit_index_q     <= bit_index_d;
      second_half_q   <= second_half_d;
      receive_shift_q <= receive_shift_d;
      bytes_left_q    <= bytes_left_d;
      cs_q            <= cs_d;
      clk_q           <= clk_d;
      mosi_q          <= mosi_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spi_command_then_read_master.sv =====
// Usage notes for the SPI command-then-read master.
// Each slave-side request is one half-bit tick of the serial clock: it carries
// a start flag, the command word, the byte count and the sampled MISO level.
// Each tick yields exactly one master-side request with the pin levels
// (chip select, clock, MOSI), the busy flag and, on the last tick of a byte,
// the received byte with tuser set; tlast marks the final byte.
// A tick passes an input register and then an output register before its result
// is presented; the result is taken when the receiver is ready.
// Throughput is one tick per cycle while the receiver is ready; the sequencer
// state advances only when the input register hands a tick on, which the output register allows.
// When the receiver stalls, the output register holds and the input register
// fills, then s_axis_tready drops; no tick is lost or repeated.
// The command bit count register is written over the cfg channel (always
// ready) and should only change while the block is idle.
// Reset leaves chip select, clock and MOSI high, the sequencer idle and the
// command bit count at 26.
// Files: spicmdrd_pkg, spicmdrd_core.
`timescale 1ns / 1ps
`default_nettype none

module spi_command_then_read_master #(
  parameter int unsigned COMMAND_WIDTH = 32,
  localparam int unsigned InWidth = ((COMMAND_WIDTH + 10 + 7) / 8) * 8
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Configuration write: command_bits.
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [spicmdrd_pkg::CfgWidth-1:0]   cfg_data_i,
  // tdata from bit 0: start_req, command_word, read_count, miso_level, zero pad.
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire [InWidth-1:0]                  s_axis_tdata,
  // tdata from bit 0: chip_select_n, serial_clock, mosi_level, read_byte,
  // busy_res, zero pad. tuser: byte_valid. tlast: last_byte.
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [spicmdrd_pkg::ResDataWidth-1:0] m_axis_tdata,
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned ItemWidth = COMMAND_WIDTH + 10;

  logic                 in_valid_q;
  logic [ItemWidth-1:0] in_item_q;
  logic                 step;
  logic                 out_valid_q;
  spicmdrd_pkg::tick_res_t res, out_res_q;

  assign cfg_ready_o   = 1'b1;
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= s_axis_tdata[ItemWidth-1:0];
    end
  end

  spicmdrd_core #(
    .COMMAND_WIDTH(COMMAND_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .step_i         (step),
    .start_req_i    (in_item_q[0]),
    .command_word_i (in_item_q[COMMAND_WIDTH:1]),
    .read_count_i   (in_item_q[COMMAND_WIDTH+8:COMMAND_WIDTH+1]),
    .miso_level_i   (in_item_q[COMMAND_WIDTH+9]),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.busy, out_res_q.rd_byte,
                          out_res_q.mosi, out_res_q.sclk, out_res_q.cs_n};
  assign m_axis_tuser  = out_res_q.byte_valid;
  assign m_axis_tlast  = out_res_q.last_byte;

endmodule

`default_nettype wire
